@@ rtl/ttcw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types, codes and escape sequence tables for the terminal text
// clip-and-wrap block.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  // symbol and field widths
  localparam int SYM_W = 21;
  localparam int CW_W  = 3;
  localparam int REG_W = 10;
  localparam int COL_W = 12;
  localparam int ROW_W = 11;

  // tab stop spacing (power of two)
  localparam int TAB_STOP = 8;

  // first row of the window
  localparam int ROW_HOME = 2;

  // characters of interest
  localparam logic [SYM_W-1:0] CH_ESC = 21'h00001B;
  localparam logic [SYM_W-1:0] CH_LF  = 21'h00000A;
  localparam logic [SYM_W-1:0] CH_TAB = 21'h000009;
  localparam logic [SYM_W-1:0] CH_LBR = 21'h00005B;
  localparam logic [SYM_W-1:0] CH_M   = 21'h00006D;
  localparam logic [SYM_W-1:0] CH_3   = 21'h000033;
  localparam logic [SYM_W-1:0] CH_0   = 21'h000030;
  localparam logic [SYM_W-1:0] CH_H   = 21'h000048;
  localparam logic [SYM_W-1:0] CH_E   = 21'h000045;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // escape tracking
  typedef enum logic [1:0] {
    ESC_NORMAL = 2'd0,
    ESC_AFTER  = 2'd1,
    ESC_CSI    = 2'd2
  } esc_phase_t;

  // frame tracking
  typedef enum logic [1:0] {
    FRM_IDLE   = 2'd0,
    FRM_ACTIVE = 2'd1,
    FRM_DONE   = 2'd2
  } frame_phase_t;

  // output segments of one item, in send order
  typedef enum logic [1:0] {
    SEG_HOME  = 2'd0,
    SEG_NL    = 2'd1,
    SEG_SYM   = 2'd2,
    SEG_CLOSE = 2'd3
  } seg_t;

  // position of the last symbol in a segment
  function automatic logic [1:0] seg_last_pos(seg_t seg);
    logic [1:0] p;
    unique case (seg)
      SEG_HOME:  p = 2'd3;
      SEG_NL:    p = 2'd2;
      SEG_SYM:   p = 2'd0;
      SEG_CLOSE: p = 2'd3;
      default:   p = 2'd0;
    endcase
    return p;
  endfunction

  // fixed escape sequence symbols; the character segment uses its own payload
  function automatic logic [SYM_W-1:0] seg_symbol(seg_t seg, logic [1:0] pos);
    logic [SYM_W-1:0] s;
    s = CH_ESC;
    unique case (pos)
      2'd0: s = CH_ESC;
      2'd1: s = CH_LBR;
      2'd2: begin
        if (seg == SEG_HOME) begin
          s = CH_3;
        end else if (seg == SEG_NL) begin
          s = CH_E;
        end else begin
          s = CH_0;
        end
      end
      2'd3: s = (seg == SEG_HOME) ? CH_H : CH_M;
      default: s = CH_ESC;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/terminal_text_clip_wrap.sv @@
// ----------------------------------------------------------------------------
// terminal_text_clip_wrap
// Lays a character stream into a terminal window starting at row 2: wraps,
// expands newline and tab, passes escape sequences, frames with home/reset.
// ----------------------------------------------------------------------------
//
//   channel | ports                                           | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid in_ready in_code_point in_char_width   | input
//           | in_stream_end                                   |
//   out     | out_valid out_ready out_symbol out_last_of_run  | output
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data          | input
//
// One input register feeds the per-item logic, which loads a burst register
// (home, next-line, character, close segments). The burst drains one symbol
// per cycle while out_ready is high; an item yields up to 12 symbols, and
// an item with no result is consumed without loading the burst. The next
// item is taken while the last symbol of the current burst goes out. Reset
// (rst_n low, synchronous) restores columns 80, rows 24 and an idle frame.
// The output holds while out_ready is low; the input register holds until
// its item can be loaded.
//
module terminal_text_clip_wrap (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ttcw_pkg::SYM_W-1:0]    in_code_point,
  input  logic signed [ttcw_pkg::CW_W-1:0] in_char_width,
  input  logic                          in_stream_end,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ttcw_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last_of_run,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [ttcw_pkg::REG_W-1:0]    cfg_data
);

  // configuration registers
  logic [ttcw_pkg::REG_W-1:0] columns_r;
  logic [ttcw_pkg::REG_W-1:0] rows_r;

  // input register
  logic                              in_v_r;
  logic [ttcw_pkg::SYM_W-1:0]        cp_r;
  logic signed [ttcw_pkg::CW_W-1:0]  w_r;
  logic                              end_r;

  // layout state
  logic [ttcw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [ttcw_pkg::ROW_W-1:0] row_r, row_nxt;
  ttcw_pkg::esc_phase_t       esc_r, esc_nxt;
  ttcw_pkg::frame_phase_t     frm_r, frm_nxt;

  // burst register
  logic [3:0]                 mask_r, mask_nxt;
  logic [1:0]                 pos_r;
  logic [ttcw_pkg::SYM_W-1:0] bsym_r;

  // per-item work signals
  logic                       ok_pre, ok_post;
  logic signed [13:0]         col_sum;
  logic [ttcw_pkg::COL_W-1:0] col_adv;
  logic [ttcw_pkg::COL_W-1:0] col_tab;
  logic [ttcw_pkg::ROW_W-1:0] row_inc;
  logic [ttcw_pkg::COL_W-1:0] lim;
  logic [ttcw_pkg::ROW_W-1:0] rlim;

  // output side signals
  ttcw_pkg::seg_t             cur_seg;
  logic                       seg_end;
  logic                       run_end;
  logic [3:0]                 cur_bit;
  logic                       out_fire;
  logic                       can_load;
  logic                       consume;

  assign cfg_ready = 1'b1;

  // config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 10'd80;
      rows_r    <= 10'd24;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttcw_pkg::CFG_COLUMNS: columns_r <= cfg_data;
        ttcw_pkg::CFG_ROWS:    rows_r    <= cfg_data;
        default:               columns_r <= columns_r;
      endcase
    end
  end

  assign lim  = {2'b00, columns_r};
  assign rlim = {1'b0, rows_r};

  function automatic logic [ttcw_pkg::ROW_W-1:0] ROW_W_INC(logic [ttcw_pkg::ROW_W-1:0] r);
    return ttcw_pkg::ROW_W'(r + 11'd1);
  endfunction

  // per-item layout: which segments to send and the next state
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    esc_nxt  = esc_r;
    frm_nxt  = frm_r;
    mask_nxt = 4'b0000;
    row_inc  = ROW_W_INC(row_r);
    col_sum  = $signed({2'b00, col_r}) + $signed({{11{w_r[2]}}, w_r});
    col_adv  = col_sum[13] ? '0 : col_sum[ttcw_pkg::COL_W-1:0];
    col_tab  = ttcw_pkg::COL_W'(col_r + (ttcw_pkg::TAB_STOP - (col_r % ttcw_pkg::TAB_STOP)));
    ok_pre   = (col_r <= lim) && (row_r < rlim);
    ok_post  = 1'b1;
    if (frm_r == ttcw_pkg::FRM_DONE) begin
      // frame finished: drop until the stream ends
      if (end_r) begin
        col_nxt = '0;
        row_nxt = ttcw_pkg::ROW_W'(ttcw_pkg::ROW_HOME);
        esc_nxt = ttcw_pkg::ESC_NORMAL;
        frm_nxt = ttcw_pkg::FRM_IDLE;
      end
    end else begin
      if (frm_r == ttcw_pkg::FRM_IDLE) begin
        mask_nxt[ttcw_pkg::SEG_HOME] = 1'b1;
        frm_nxt = ttcw_pkg::FRM_ACTIVE;
      end
      if (!ok_pre || end_r) begin
        mask_nxt[ttcw_pkg::SEG_CLOSE] = 1'b1;
        if (end_r) begin
          col_nxt = '0;
          row_nxt = ttcw_pkg::ROW_W'(ttcw_pkg::ROW_HOME);
          esc_nxt = ttcw_pkg::ESC_NORMAL;
          frm_nxt = ttcw_pkg::FRM_IDLE;
        end else begin
          frm_nxt = ttcw_pkg::FRM_DONE;
        end
      end else begin
        if (esc_r == ttcw_pkg::ESC_CSI) begin
          // inside a control sequence: pass until the final 'm'
          mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
          if (cp_r == ttcw_pkg::CH_M) begin
            esc_nxt = ttcw_pkg::ESC_NORMAL;
          end
        end else if (esc_r == ttcw_pkg::ESC_AFTER && cp_r == ttcw_pkg::CH_LBR) begin
          mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
          esc_nxt = ttcw_pkg::ESC_CSI;
        end else begin
          esc_nxt = ttcw_pkg::ESC_NORMAL;
          priority if (cp_r == ttcw_pkg::CH_ESC) begin
            mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
            esc_nxt = ttcw_pkg::ESC_AFTER;
          end else if (cp_r == ttcw_pkg::CH_LF) begin
            row_nxt = row_inc;
            col_nxt = '0;
            if (row_inc < rlim) begin
              mask_nxt[ttcw_pkg::SEG_NL] = 1'b1;
            end
          end else if (cp_r == ttcw_pkg::CH_TAB) begin
            if (col_tab > lim) begin
              row_nxt = row_inc;
              col_nxt = ttcw_pkg::COL_W'(ttcw_pkg::TAB_STOP);
              if (row_inc < rlim) begin
                mask_nxt[ttcw_pkg::SEG_NL]  = 1'b1;
                mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
              end
            end else begin
              col_nxt = col_tab;
              mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
            end
          end else begin
            // printable: wrap when the new column passes the limit
            if (col_adv > lim) begin
              row_nxt = row_inc;
              col_nxt = {10'b0, w_r[1:0]};
              if (row_inc < rlim) begin
                mask_nxt[ttcw_pkg::SEG_NL]  = 1'b1;
                mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
              end
            end else begin
              col_nxt = col_adv;
              mask_nxt[ttcw_pkg::SEG_SYM] = 1'b1;
            end
          end
        end
        // close when the item leaves the window
        ok_post = (col_nxt <= lim) && (row_nxt < rlim);
        if (!ok_post) begin
          mask_nxt[ttcw_pkg::SEG_CLOSE] = 1'b1;
          frm_nxt = ttcw_pkg::FRM_DONE;
        end
      end
    end
  end

  // current segment is the lowest pending one
  always_comb begin
    priority if (mask_r[ttcw_pkg::SEG_HOME]) begin
      cur_seg = ttcw_pkg::SEG_HOME;
    end else if (mask_r[ttcw_pkg::SEG_NL]) begin
      cur_seg = ttcw_pkg::SEG_NL;
    end else if (mask_r[ttcw_pkg::SEG_SYM]) begin
      cur_seg = ttcw_pkg::SEG_SYM;
    end else begin
      cur_seg = ttcw_pkg::SEG_CLOSE;
    end
    cur_bit = 4'b0001 << cur_seg;
    seg_end = (pos_r == ttcw_pkg::seg_last_pos(cur_seg));
    run_end = seg_end && ((mask_r & ~cur_bit) == 4'b0000);
  end

  assign out_valid       = (mask_r != 4'b0000);
  assign out_symbol      = (cur_seg == ttcw_pkg::SEG_SYM) ? bsym_r
                                                          : ttcw_pkg::seg_symbol(cur_seg, pos_r);
  assign out_last_of_run = run_end;
  assign out_fire        = out_valid && out_ready;

  // handoff between input register and burst register
  assign can_load = !out_valid || (out_fire && run_end);
  assign consume  = in_v_r && (can_load || (mask_nxt == 4'b0000));
  assign in_ready = !in_v_r || consume;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cp_r  <= in_code_point;
      w_r   <= in_char_width;
      end_r <= in_stream_end;
    end
  end

  // layout state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= ttcw_pkg::ROW_W'(ttcw_pkg::ROW_HOME);
      esc_r <= ttcw_pkg::ESC_NORMAL;
      frm_r <= ttcw_pkg::FRM_IDLE;
    end else if (consume) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      esc_r <= esc_nxt;
      frm_r <= frm_nxt;
    end
  end

  // burst register: load a new item or step through the pending segments
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'b0000;
      pos_r  <= 2'd0;
    end else if (consume && (mask_nxt != 4'b0000)) begin
      mask_r <= mask_nxt;
      pos_r  <= 2'd0;
    end else if (out_fire) begin
      if (seg_end) begin
        mask_r <= mask_r & ~cur_bit;
        pos_r  <= 2'd0;
      end else begin
        pos_r  <= 2'(pos_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && (mask_nxt != 4'b0000)) begin
      bsym_r <= cp_r;
    end
  end

`ifndef SYNTHESIS
  // idle frame always sits at the window origin in normal text
  a_idle_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (frm_r == ttcw_pkg::FRM_IDLE) |->
      (col_r == '0 && row_r == ttcw_pkg::ROW_W'(ttcw_pkg::ROW_HOME)
       && esc_r == ttcw_pkg::ESC_NORMAL))
    else $error("idle frame not at origin");

  // row never falls below the window top
  a_row_floor: assert property (@(posedge clk) disable iff (!rst_n)
    row_r >= ttcw_pkg::ROW_W'(ttcw_pkg::ROW_HOME))
    else $error("row below window top");

  // next-line segment is three symbols long
  a_nl_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cur_seg == ttcw_pkg::SEG_NL) |-> (pos_r != 2'd3))
    else $error("next-line position out of range");

  // final symbol taken with nothing waiting leaves the burst empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && run_end && !in_v_r) |=> (mask_r == 4'b0000))
    else $error("burst not empty after last symbol");
`endif

endmodule

@@ dv/terminal_text_clip_wrap_test.sv @@
// ----------------------------------------------------------------------------
// terminal_text_clip_wrap_test
// Self-checking bench for the terminal clip-and-wrap block: a directed table
// followed by random character streams over several window sizes, with an
// in-bench layout predictor checking every symbol in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_text_clip_wrap_test;

  localparam int RANDOM_ITEMS  = 180;
  localparam int CALM_ITEMS    = 40;
  localparam int PHASE_ITEMS   = 25;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 40;

  // character widths
  localparam logic signed [ttcw_pkg::CW_W-1:0] W_NP = -3'sd1;
  localparam logic signed [ttcw_pkg::CW_W-1:0] W_0  = 3'sd0;
  localparam logic signed [ttcw_pkg::CW_W-1:0] W_1  = 3'sd1;
  localparam logic signed [ttcw_pkg::CW_W-1:0] W_2  = 3'sd2;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic                             idx;
    logic [ttcw_pkg::REG_W-1:0]       val;
    logic [ttcw_pkg::SYM_W-1:0]       cp;
    logic signed [ttcw_pkg::CW_W-1:0] w;
    logic                             se;
  } row_t;

  typedef struct packed {
    logic [ttcw_pkg::SYM_W-1:0] sym;
    logic                       last;
  } sym_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [ttcw_pkg::SYM_W-1:0]       in_code_point = '0;
  logic signed [ttcw_pkg::CW_W-1:0] in_char_width = '0;
  logic                             in_stream_end = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [ttcw_pkg::SYM_W-1:0]       out_symbol;
  logic                             out_last_of_run;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_index = ttcw_pkg::CFG_COLUMNS;
  logic [ttcw_pkg::REG_W-1:0]       cfg_data = '0;

  // predictor state and window registers
  int                     win_cols;
  int                     win_rows;
  int                     col_pos;
  int                     row_pos;
  ttcw_pkg::esc_phase_t   esc_st;
  ttcw_pkg::frame_phase_t frm_st;

  sym_t  screen_q[$];
  sym_t  burst_q[$];
  row_t  dir_rows[$];
  string row_typed[$];
  int    typed_row = -1;

  int   errors = 0;
  int   live_items = 0;
  int   idle_cycles = 0;
  int   hold_ask = 0;
  int   hold_served = 0;
  logic calm = 1'b0;
  bit   pressing = 1'b0;

  terminal_text_clip_wrap DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_point   (in_code_point),
    .in_char_width   (in_char_width),
    .in_stream_end   (in_stream_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit window_fits();
    return col_pos <= win_cols && row_pos < win_rows;
  endfunction

  task automatic put_sym(logic [ttcw_pkg::SYM_W-1:0] s);
    sym_t e;
    e.sym  = s;
    e.last = 1'b0;
    burst_q.push_back(e);
  endtask

  // ESC [ b c
  task automatic put_csi(logic [ttcw_pkg::SYM_W-1:0] b, logic [ttcw_pkg::SYM_W-1:0] c);
    put_sym(ttcw_pkg::CH_ESC);
    put_sym(ttcw_pkg::CH_LBR);
    put_sym(b);
    put_sym(c);
  endtask

  task automatic put_next_line();
    put_sym(ttcw_pkg::CH_ESC);
    put_sym(ttcw_pkg::CH_LBR);
    put_sym(ttcw_pkg::CH_E);
  endtask

  task automatic go_idle();
    col_pos = 0;
    row_pos = ttcw_pkg::ROW_HOME;
    esc_st  = ttcw_pkg::ESC_NORMAL;
    frm_st  = ttcw_pkg::FRM_IDLE;
  endtask

  task automatic close_frame(bit at_end);
    put_csi(ttcw_pkg::CH_0, ttcw_pkg::CH_M);
    if (at_end) begin
      go_idle();
    end else begin
      frm_st = ttcw_pkg::FRM_DONE;
    end
  endtask

  // ordinary text: escape start, newline, tab, or a printed character
  task automatic place_char(logic [ttcw_pkg::SYM_W-1:0] cp, int w);
    if (cp == ttcw_pkg::CH_ESC) begin
      put_sym(cp);
      esc_st = ttcw_pkg::ESC_AFTER;
      return;
    end
    if (cp == ttcw_pkg::CH_LF) begin
      row_pos++;
      col_pos = 0;
      if (row_pos >= win_rows) return;
      put_next_line();
      return;
    end
    if (cp == ttcw_pkg::CH_TAB) begin
      col_pos += ttcw_pkg::TAB_STOP - (col_pos % ttcw_pkg::TAB_STOP);
      if (col_pos > win_cols) begin
        row_pos++;
        col_pos = ttcw_pkg::TAB_STOP;
        if (row_pos >= win_rows) return;
        put_next_line();
      end
      put_sym(cp);
      return;
    end
    col_pos += w;
    if (col_pos < 0) col_pos = 0;
    if (col_pos > win_cols) begin
      row_pos++;
      col_pos = w;
      if (row_pos >= win_rows) return;
      put_next_line();
    end
    put_sym(cp);
  endtask

  // work out the symbols one accepted item causes and queue them
  task automatic lay_out_item(logic [ttcw_pkg::SYM_W-1:0] cp,
                              logic signed [ttcw_pkg::CW_W-1:0] w,
                              logic se, int row);
    int    wi;
    string typed;
    sym_t  e;
    wi = w;
    typed = (row >= 0) ? row_typed[row] : "";
    burst_q.delete();
    if (frm_st != ttcw_pkg::FRM_IDLE && frm_st != ttcw_pkg::FRM_ACTIVE) begin
      if (se) go_idle();
      return;
    end
    if (frm_st == ttcw_pkg::FRM_IDLE) begin
      put_csi(ttcw_pkg::CH_3, ttcw_pkg::CH_H);
      frm_st = ttcw_pkg::FRM_ACTIVE;
    end
    if (!window_fits() || se) begin
      close_frame(se);
    end else begin
      if (esc_st == ttcw_pkg::ESC_CSI) begin
        put_sym(cp);
        if (cp == ttcw_pkg::CH_M) esc_st = ttcw_pkg::ESC_NORMAL;
      end else if (esc_st == ttcw_pkg::ESC_AFTER && cp == ttcw_pkg::CH_LBR) begin
        put_sym(cp);
        esc_st = ttcw_pkg::ESC_CSI;
      end else begin
        esc_st = ttcw_pkg::ESC_NORMAL;
        place_char(cp, wi);
      end
      if (!window_fits()) close_frame(1'b0);
    end
    if (burst_q.size() > 0) burst_q[burst_q.size()-1].last = 1'b1;
    // a typed row stands in for the prediction
    if (typed != "") begin
      for (int i = 0; i < typed.len(); i++) begin
        e.sym  = {13'd0, typed[i]};
        e.last = (i == typed.len() - 1);
        screen_q.push_back(e);
      end
    end else begin
      foreach (burst_q[i]) screen_q.push_back(burst_q[i]);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [ttcw_pkg::SYM_W-1:0] want,
                                 logic [ttcw_pkg::SYM_W-1:0] got);
    if (errors < PRINT_LIMIT)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    errors++;
  endtask

  // accepted items, register writes and symbols
  always @(posedge clk) begin : watch_ports
    sym_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        live_items++;
        lay_out_item(in_code_point, in_char_width, in_stream_end, typed_row);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ttcw_pkg::CFG_COLUMNS) begin
          win_cols = int'(cfg_data);
        end else begin
          win_rows = int'(cfg_data);
        end
      end
      if (out_valid && out_ready) begin
        if (screen_q.size() == 0) begin
          report_mismatch("symbol with nothing pending", '0, out_symbol);
        end else begin
          want = screen_q.pop_front();
          if (out_symbol !== want.sym)
            report_mismatch("out_symbol", want.sym, out_symbol);
          if (out_last_of_run !== want.last)
            report_mismatch("out_last_of_run", ttcw_pkg::SYM_W'(want.last),
                            ttcw_pkg::SYM_W'(out_last_of_run));
        end
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("terminal_text_clip_wrap_test NOT OK");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stalls, one long hold-off on request, none in the calm part
  initial begin
    @(posedge clk);
    forever begin
      if (hold_ask != hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = hold_served + 1;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_item(logic [ttcw_pkg::SYM_W-1:0] cp,
                           logic signed [ttcw_pkg::CW_W-1:0] w,
                           logic se, int row);
    in_valid      <= 1'b1;
    in_code_point <= cp;
    in_char_width <= w;
    in_stream_end <= se;
    typed_row     <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && !pressing && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // register write once every pending symbol is out
  task automatic write_reg(logic idx, logic [ttcw_pkg::REG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (screen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(logic [ttcw_pkg::SYM_W-1:0] cp,
                          logic signed [ttcw_pkg::CW_W-1:0] w,
                          logic se, string typed);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cp   = cp;
    r.w    = w;
    r.se   = se;
    dir_rows.push_back(r);
    row_typed.push_back(typed);
  endtask

  task automatic add_cfg(logic idx, logic [ttcw_pkg::REG_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    dir_rows.push_back(r);
    row_typed.push_back("");
  endtask

  // random width from nonprintable up to double
  function automatic logic signed [ttcw_pkg::CW_W-1:0] rand_width();
    return ttcw_pkg::CW_W'($urandom_range(0, 3) - 1);
  endfunction

  // one stream of random text closed by a stream end
  task automatic send_text(int len);
    int k;
    int pick;
    int digits;
    k = 0;
    while (k < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_item(ttcw_pkg::SYM_W'($urandom_range(32, 126)), W_1, 1'b0, -1);
      end else if (pick < 60) begin
        send_item(ttcw_pkg::SYM_W'($urandom_range(21'h4E00, 21'h9FFF)), W_2, 1'b0, -1);
      end else if (pick < 65) begin
        send_item(ttcw_pkg::SYM_W'($urandom_range(21'h300, 21'h36F)), W_0, 1'b0, -1);
      end else if (pick < 70) begin
        send_item(ttcw_pkg::SYM_W'($urandom_range(0, 31)), W_NP, 1'b0, -1);
      end else if (pick < 78) begin
        send_item(ttcw_pkg::CH_LF, W_NP, 1'b0, -1);
      end else if (pick < 85) begin
        send_item(ttcw_pkg::CH_TAB, W_NP, 1'b0, -1);
      end else if (pick < 93) begin
        // attribute sequence, now and then left open
        send_item(ttcw_pkg::CH_ESC, W_NP, 1'b0, -1);
        send_item(ttcw_pkg::CH_LBR, W_1, 1'b0, -1);
        digits = $urandom_range(0, 3);
        repeat (digits)
          send_item(ttcw_pkg::SYM_W'($urandom_range(21'h30, 21'h3B)), W_1, 1'b0, -1);
        if ($urandom_range(0, 7) != 0) send_item(ttcw_pkg::CH_M, W_1, 1'b0, -1);
        k += 2 + digits;
      end else if (pick < 96) begin
        send_item(ttcw_pkg::CH_ESC, W_NP, 1'b0, -1);
        send_item(ttcw_pkg::SYM_W'($urandom_range(32, 126)), W_1, 1'b0, -1);
        k++;
      end else if (pick < 99) begin
        send_item(ttcw_pkg::SYM_W'($urandom_range(0, 1114111)), rand_width(), 1'b0, -1);
      end else begin
        send_item(ttcw_pkg::SYM_W'($urandom_range(0, 21'h1FFFFF)), rand_width(), 1'b0, -1);
      end
      k++;
    end
    send_item(ttcw_pkg::SYM_W'($urandom_range(0, 21'h1FFFFF)), rand_width(), 1'b1, -1);
  endtask

  // ---------------------------------------------------------------- main flow

  int set_cols[6] = '{1023, 0, 0, 1023, 2, 80};
  int set_rows[6] = '{1023, 0, 6, 3, 1023, 24};

  initial begin : main_flow
    int phase;
    int target;
    int stop_at;
    int c;
    int r;
    win_cols = 80;
    win_rows = 24;
    go_idle();

    // empty stream, first item, extremes, escapes
    add_item('0, W_0, 1'b1, "\033[3H\033[0m");
    add_item(ttcw_pkg::SYM_W'("A"), W_1, 1'b0, "\033[3HA");
    add_item(21'h1FFFFF, W_2, 1'b0, "");
    add_item('0, W_0, 1'b0, "");
    add_item(ttcw_pkg::CH_TAB, W_NP, 1'b0, "");
    add_item(ttcw_pkg::CH_LF, W_NP, 1'b0, "");
    add_item(ttcw_pkg::SYM_W'("B"), W_NP, 1'b0, "");
    add_item(ttcw_pkg::CH_ESC, W_NP, 1'b0, "");
    add_item(ttcw_pkg::CH_LBR, W_1, 1'b0, "");
    add_item(ttcw_pkg::SYM_W'("5"), W_1, 1'b0, "");
    add_item(ttcw_pkg::CH_M, W_1, 1'b0, "");
    add_item(ttcw_pkg::CH_ESC, W_NP, 1'b0, "");
    add_item(ttcw_pkg::SYM_W'("x"), W_1, 1'b0, "");
    add_item(ttcw_pkg::CH_ESC, W_NP, 1'b0, "");
    add_item(ttcw_pkg::CH_LBR, W_1, 1'b0, "");
    add_item('0, W_0, 1'b1, "");
    // overflow after wrap, then dropped items up to the stream end
    add_cfg(ttcw_pkg::CFG_COLUMNS, 10'd1);
    add_cfg(ttcw_pkg::CFG_ROWS, 10'd4);
    add_item(ttcw_pkg::SYM_W'("W"), W_2, 1'b0, "");
    add_item(ttcw_pkg::SYM_W'("y"), W_1, 1'b0, "");
    add_item('0, W_0, 1'b1, "");
    // window too small for any text
    add_cfg(ttcw_pkg::CFG_ROWS, 10'd2);
    add_item(ttcw_pkg::SYM_W'("z"), W_1, 1'b0, "\033[3H\033[0m");
    add_item('0, W_0, 1'b1, "");
    // row limit lowered in the middle of a frame
    add_cfg(ttcw_pkg::CFG_COLUMNS, 10'd80);
    add_cfg(ttcw_pkg::CFG_ROWS, 10'd24);
    add_item(ttcw_pkg::SYM_W'("a"), W_1, 1'b0, "");
    add_cfg(ttcw_pkg::CFG_ROWS, 10'd2);
    add_item(ttcw_pkg::SYM_W'("b"), W_1, 1'b0, "");
    add_item('0, W_0, 1'b1, "");
    // newline that reaches the row limit
    add_cfg(ttcw_pkg::CFG_ROWS, 10'd3);
    add_item(ttcw_pkg::CH_LF, W_NP, 1'b0, "");
    add_item('0, W_0, 1'b1, "");

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].cp, dir_rows[i].w, dir_rows[i].se, i);
      end
    end

    // random streams, one window setting per phase
    phase  = 0;
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) begin
      if (phase < 6) begin
        c = set_cols[phase];
        r = set_rows[phase];
      end else begin
        c = $urandom_range(0, 24);
        r = $urandom_range(0, 9);
      end
      write_reg(ttcw_pkg::CFG_COLUMNS, ttcw_pkg::REG_W'(c));
      write_reg(ttcw_pkg::CFG_ROWS, ttcw_pkg::REG_W'(r));
      if (phase == 0) begin
        // receiver holds off while items keep coming
        hold_ask <= hold_ask + 1;
        pressing = 1'b1;
        send_text(30);
        pressing = 1'b0;
      end
      stop_at = live_items + PHASE_ITEMS;
      while (live_items < stop_at && live_items < target) begin
        if (live_items >= target - CALM_ITEMS) calm <= 1'b1;
        send_text($urandom_range(1, 30));
      end
      phase++;
    end

    // drain and finish
    in_valid <= 1'b0;
    @(posedge clk);
    while (screen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("terminal_text_clip_wrap_test OK");
    end else begin
      $display("terminal_text_clip_wrap_test NOT OK");
    end
    $finish;
  end

endmodule
